// ----- rtl/ndt_pkg.sv -----
// ndt_pkg: widths, thermistor tables, codes and controller/datapath types
// for the NTC divider temperature block. No dependencies.
`default_nettype none

package ndt_pkg;

    localparam int TABLE_SIZE = 42;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int RES_W      = 27;
    localparam int TT_W       = 12;

    localparam int ADC_W      = 14;
    localparam int SUPPLY_W   = 14;
    localparam int RF_OHM_W   = 20;
    localparam int TEMP_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int RSUM_W  = RES_W + 1;
    localparam int DT_W    = TT_W + 1;
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 15;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 42;
    localparam int DEN_W   = 15;
    localparam int N_W     = 56;
    localparam int QUO_W   = TT_W;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam int OHM_TO_CENTI = 100;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    localparam logic [RES_W-1:0] TABLE_RES [TABLE_SIZE] = '{
        27'd96158000, 27'd66892000, 27'd47127000, 27'd33606000, 27'd24243000,
        27'd17681000, 27'd13032000, 27'd9702000,  27'd7292300,  27'd5531400,
        27'd4232500,  27'd3265700,  27'd2540000,  27'd1990700,  27'd1571600,
        27'd1249400,  27'd1000000,  27'd805520,   27'd652880,   27'd532290,
        27'd436450,   27'd359810,   27'd298190,   27'd248370,   27'd207870,
        27'd174790,   27'd147630,   27'd125230,   27'd106670,   27'd91227,
        27'd78319,    27'd67488,    27'd58363,    27'd50647,    27'd44098,
        27'd38520,    27'd33752,    27'd29663,    27'd26146,    27'd23111,
        27'd20484,    27'd18203
    };

    localparam logic signed [TT_W-1:0] TABLE_TEMP [TABLE_SIZE] = '{
        -12'sd550, -12'sd500, -12'sd450, -12'sd400, -12'sd350, -12'sd300,
        -12'sd250, -12'sd200, -12'sd150, -12'sd100, -12'sd50,  12'sd0,
        12'sd50,   12'sd100,  12'sd150,  12'sd200,  12'sd250,  12'sd300,
        12'sd350,  12'sd400,  12'sd450,  12'sd500,  12'sd550,  12'sd600,
        12'sd650,  12'sd700,  12'sd750,  12'sd800,  12'sd850,  12'sd900,
        12'sd950,  12'sd1000, 12'sd1050, 12'sd1100, 12'sd1150, 12'sd1200,
        12'sd1250, 12'sd1300, 12'sd1350, 12'sd1400, 12'sd1450, 12'sd1500
    };

    localparam logic [RES_W-1:0] RES_FIRST = TABLE_RES[0];
    localparam logic [RES_W-1:0] RES_LAST  = TABLE_RES[TABLE_SIZE-1];

    localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -16'sd550;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 16'sd1500;
    localparam logic signed [TEMP_W-1:0] TEMP_ABOVE = -16'sd32768;
    localparam logic signed [TEMP_W-1:0] TEMP_BELOW = 16'sd32767;

    localparam logic [STATUS_W-1:0] STAT_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ABOVE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BELOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_RESISTOR_OHM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NTC_IS_UPPER       = 2'd2;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 14'd3000;
    localparam logic [RF_OHM_W-1:0] RF_RESET     = 20'd10000;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PREP, ST_A1, ST_A2, ST_A3, ST_B2, ST_B3, ST_NUMDEN,
        ST_CL1, ST_CL2, ST_CL3, ST_SCAN0, ST_SCAN, ST_SEG_D, ST_SEG_X,
        ST_SEG_N1, ST_SEG_N2, ST_SEG_N3, ST_DIV0, ST_DIV, ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_PREP, OP_SAVE, OP_ABOVE, OP_BELOW, OP_NUM,
        OP_CLAMP_HI, OP_CLAMP_LO, OP_SCAN_INIT, OP_SCAN, OP_D, OP_X, OP_N,
        OP_NACC, OP_DIV_INIT, OP_DIV_STEP
    } dp_op_t;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_A1, MUL_A2, MUL_B1, MUL_B2, MUL_NUM, MUL_R0_DEN,
        MUL_RL_DEN, MUL_SCAN, MUL_DIFF, MUL_RA_DEN, MUL_TA_D, MUL_DT_X
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul;
        logic     load_out;
    } ndt_cmd_t;

    typedef struct packed {
        logic gt_save;
        logic lt_save;
        logic num_gt;
        logic scan_hit;
        logic div_last;
    } ndt_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ndt_if.sv -----
// ndt_if: valid/ready channel interfaces for sample, result and config words.
// Depends on ndt_pkg for field widths.
`default_nettype none

interface ndt_in_if
    import ndt_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_mv;

    modport source (output valid, output adc_mv, input ready);
    modport sink   (input valid, input adc_mv, output ready);
endinterface

interface ndt_out_if
    import ndt_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_ddegc;
    logic [STATUS_W-1:0]      range_status;

    modport source (output valid, output temp_ddegc, output range_status, input ready);
    modport sink   (input valid, input temp_ddegc, input range_status, output ready);
endinterface

interface ndt_cfg_if
    import ndt_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ndt_datapath.sv -----
// ndt_datapath: shared multiplier, range checks, table scan, interpolation
// and restoring divider. Depends on ndt_pkg; driven by ndt_controller.
`default_nettype none

module ndt_datapath
    import ndt_pkg::*;
(
    input  logic                     clk,
    input  ndt_cmd_t                 cmd,
    output ndt_stat_t                stat,
    input  logic [ADC_W-1:0]         adc_mv,
    input  logic [SUPPLY_W-1:0]      supply_mv,
    input  logic [RF_OHM_W-1:0]      fixed_resistor_ohm,
    input  logic                     ntc_is_upper,
    output logic signed [TEMP_W-1:0] temp_ddegc,
    output logic [STATUS_W-1:0]      range_status
);

    logic [ADC_W-1:0]          adc_reg;
    logic [SUPPLY_W-1:0]       vs_reg;
    logic                      upper_reg;
    logic [RES_W-1:0]          rf_reg;
    logic [RSUM_W-1:0]         rsum_hi_reg;
    logic [RSUM_W-1:0]         rsum_lo_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  save_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [DEN_W-1:0]   den_reg;
    idx_t                      idx_reg;
    idx_t                      seg_reg;
    logic signed [NUM_W-1:0]   d_reg;
    logic signed [NUM_W-1:0]   x_reg;
    logic signed [N_W-1:0]     n_reg;
    logic [N_W-1:0]            rem_reg;
    logic [N_W-1:0]            dsh_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      neg_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [TEMP_W-1:0]  temp_out_reg;
    logic [STATUS_W-1:0]       status_out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [DEN_W-1:0]   diff_vs;
    idx_t                      seg_nxt;
    idx_t                      scan_addr;
    logic signed [RES_W:0]     seg_diff;
    logic signed [TT_W-1:0]    ta;
    logic signed [TT_W-1:0]    tb;
    logic signed [DT_W-1:0]    dt;
    logic signed [PROD_W-1:0]  num_ext;
    logic [NUM_W-1:0]          d_abs;
    logic [N_W-1:0]            n_abs;
    logic [TEMP_W-1:0]         quo_ext;

    assign diff_vs  = $signed({1'b0, vs_reg}) - $signed({1'b0, adc_reg});
    assign seg_nxt  = seg_reg + IDX_W'(1);
    assign ta       = TABLE_TEMP[seg_reg];
    assign tb       = TABLE_TEMP[seg_nxt];
    assign dt       = DT_W'(tb) - DT_W'(ta);
    assign seg_diff = $signed({1'b0, TABLE_RES[seg_nxt]}) - $signed({1'b0, TABLE_RES[seg_reg]});
    assign num_ext  = PROD_W'(num_reg);
    assign d_abs    = d_reg[NUM_W-1] ? $unsigned(-d_reg) : $unsigned(d_reg);
    assign n_abs    = n_reg[N_W-1] ? $unsigned(-n_reg) : $unsigned(n_reg);
    assign quo_ext  = {{(TEMP_W-QUO_W){1'b0}}, quo_reg};

    always_comb
    begin
        if (cmd.op == OP_SCAN_INIT)
        begin
            scan_addr = IDX_W'(1);
        end
        else if (idx_reg == LAST_IDX)
        begin
            scan_addr = idx_reg;
        end
        else
        begin
            scan_addr = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_A1:
            begin
                mul_a = MUL_A_W'(upper_reg ? rsum_lo_reg : rsum_hi_reg);
                mul_b = MUL_B_W'(adc_reg);
            end
            MUL_A2:
            begin
                mul_a = MUL_A_W'(upper_reg ? rf_reg : RES_FIRST);
                mul_b = MUL_B_W'(vs_reg);
            end
            MUL_B1:
            begin
                mul_a = MUL_A_W'(upper_reg ? rsum_hi_reg : rsum_lo_reg);
                mul_b = MUL_B_W'(adc_reg);
            end
            MUL_B2:
            begin
                mul_a = MUL_A_W'(upper_reg ? rf_reg : RES_LAST);
                mul_b = MUL_B_W'(vs_reg);
            end
            MUL_NUM:
            begin
                mul_a = MUL_A_W'(rf_reg);
                mul_b = upper_reg ? diff_vs : MUL_B_W'(adc_reg);
            end
            MUL_R0_DEN:
            begin
                mul_a = MUL_A_W'(RES_FIRST);
                mul_b = den_reg;
            end
            MUL_RL_DEN:
            begin
                mul_a = MUL_A_W'(RES_LAST);
                mul_b = den_reg;
            end
            MUL_SCAN:
            begin
                mul_a = MUL_A_W'(TABLE_RES[scan_addr]);
                mul_b = den_reg;
            end
            MUL_DIFF:
            begin
                mul_a = MUL_A_W'(seg_diff);
                mul_b = den_reg;
            end
            MUL_RA_DEN:
            begin
                mul_a = MUL_A_W'(TABLE_RES[seg_reg]);
                mul_b = den_reg;
            end
            MUL_TA_D:
            begin
                mul_a = d_reg;
                mul_b = MUL_B_W'(ta);
            end
            MUL_DT_X:
            begin
                mul_a = x_reg;
                mul_b = MUL_B_W'(dt);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign stat.gt_save  = save_reg > prod_reg;
    assign stat.lt_save  = save_reg < prod_reg;
    assign stat.num_gt   = num_ext > prod_reg;
    assign stat.scan_hit = (prod_reg > num_ext) && (idx_reg != LAST_IDX);
    assign stat.div_last = cnt_reg == '0;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (cmd.op)
            OP_CAPTURE:
            begin
                adc_reg    <= adc_mv;
                vs_reg     <= supply_mv;
                upper_reg  <= ntc_is_upper;
                rf_reg     <= RES_W'(fixed_resistor_ohm) * RES_W'(OHM_TO_CENTI);
                status_reg <= STAT_VALID;
            end
            OP_PREP:
            begin
                rsum_hi_reg <= RSUM_W'(rf_reg) + RSUM_W'(RES_FIRST);
                rsum_lo_reg <= RSUM_W'(rf_reg) + RSUM_W'(RES_LAST);
            end
            OP_SAVE:
            begin
                save_reg <= prod_reg;
            end
            OP_ABOVE:
            begin
                if (stat.gt_save)
                begin
                    status_reg <= STAT_ABOVE;
                end
            end
            OP_BELOW:
            begin
                if (stat.lt_save)
                begin
                    status_reg <= STAT_BELOW;
                end
                den_reg <= upper_reg ? DEN_W'(adc_reg) : diff_vs;
            end
            OP_NUM:
            begin
                // zero or negative divider current: take the top of the table
                if (den_reg[DEN_W-1] || (den_reg == '0))
                begin
                    num_reg <= NUM_W'(RES_FIRST);
                    den_reg <= DEN_W'(1);
                end
                else
                begin
                    num_reg <= $signed(prod_reg[NUM_W-1:0]);
                end
            end
            OP_CLAMP_HI:
            begin
                if (stat.num_gt)
                begin
                    num_reg <= NUM_W'(RES_FIRST);
                    den_reg <= DEN_W'(1);
                end
            end
            OP_CLAMP_LO:
            begin
                if (num_ext < prod_reg)
                begin
                    num_reg <= NUM_W'(RES_LAST);
                    den_reg <= DEN_W'(1);
                end
            end
            OP_SCAN_INIT:
            begin
                idx_reg <= IDX_W'(1);
                seg_reg <= '0;
            end
            OP_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    seg_reg <= idx_reg;
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            OP_D:
            begin
                d_reg <= $signed(prod_reg[NUM_W-1:0]);
            end
            OP_X:
            begin
                x_reg <= num_reg - $signed(prod_reg[NUM_W-1:0]);
            end
            OP_N:
            begin
                n_reg <= $signed(prod_reg[N_W-1:0]);
            end
            OP_NACC:
            begin
                n_reg <= n_reg + $signed(prod_reg[N_W-1:0]);
            end
            OP_DIV_INIT:
            begin
                rem_reg <= n_abs;
                dsh_reg <= N_W'({d_abs, {(QUO_W-1){1'b0}}});
                neg_reg <= n_reg[N_W-1] ^ d_reg[NUM_W-1];
                quo_reg <= '0;
                cnt_reg <= CNT_W'(QUO_W - 1);
            end
            OP_DIV_STEP:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            status_out_reg <= status_reg;
            case (status_reg)
                STAT_ABOVE: temp_out_reg <= TEMP_ABOVE;
                STAT_BELOW: temp_out_reg <= TEMP_BELOW;
                default:    temp_out_reg <= neg_reg ? $signed(-quo_ext) : $signed(quo_ext);
            endcase
        end
    end

    assign temp_ddegc   = temp_out_reg;
    assign range_status = status_out_reg;

endmodule

`default_nettype wire

// ----- rtl/ndt_controller.sv -----
// ndt_controller: sequencer for range check, clamp, table scan, interpolation
// and division; owns the result valid flag. Depends on ndt_pkg.
`default_nettype none

module ndt_controller
    import ndt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    output logic      result_valid,
    input  logic      result_ready,
    input  ndt_stat_t stat,
    output ndt_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   load_ok;

    assign load_ok = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = sample_valid ? ST_PREP : ST_IDLE;
            ST_PREP:   state_next = ST_A1;
            ST_A1:     state_next = ST_A2;
            ST_A2:     state_next = ST_A3;
            ST_A3:     state_next = stat.gt_save ? ST_FINISH : ST_B2;
            ST_B2:     state_next = ST_B3;
            ST_B3:     state_next = stat.lt_save ? ST_FINISH : ST_NUMDEN;
            ST_NUMDEN: state_next = ST_CL1;
            ST_CL1:    state_next = ST_CL2;
            ST_CL2:    state_next = stat.num_gt ? ST_SCAN0 : ST_CL3;
            ST_CL3:    state_next = ST_SCAN0;
            ST_SCAN0:  state_next = ST_SCAN;
            ST_SCAN:   state_next = stat.scan_hit ? ST_SCAN : ST_SEG_D;
            ST_SEG_D:  state_next = ST_SEG_X;
            ST_SEG_X:  state_next = ST_SEG_N1;
            ST_SEG_N1: state_next = ST_SEG_N2;
            ST_SEG_N2: state_next = ST_SEG_N3;
            ST_SEG_N3: state_next = ST_DIV0;
            ST_DIV0:   state_next = ST_DIV;
            ST_DIV:    state_next = stat.div_last ? ST_FINISH : ST_DIV;
            ST_FINISH: state_next = load_ok ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_ready = 1'b0;
        cmd.op       = OP_NONE;
        cmd.mul      = MUL_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.op       = sample_valid ? OP_CAPTURE : OP_NONE;
            end
            ST_PREP:   cmd.op = OP_PREP;
            ST_A1:     cmd.mul = MUL_A1;
            ST_A2:
            begin
                cmd.mul = MUL_A2;
                cmd.op  = OP_SAVE;
            end
            ST_A3:
            begin
                cmd.mul = MUL_B1;
                cmd.op  = OP_ABOVE;
            end
            ST_B2:
            begin
                cmd.mul = MUL_B2;
                cmd.op  = OP_SAVE;
            end
            ST_B3:
            begin
                cmd.mul = MUL_NUM;
                cmd.op  = OP_BELOW;
            end
            ST_NUMDEN: cmd.op = OP_NUM;
            ST_CL1:    cmd.mul = MUL_R0_DEN;
            ST_CL2:
            begin
                cmd.mul = MUL_RL_DEN;
                cmd.op  = OP_CLAMP_HI;
            end
            ST_CL3:    cmd.op = OP_CLAMP_LO;
            ST_SCAN0:
            begin
                cmd.mul = MUL_SCAN;
                cmd.op  = OP_SCAN_INIT;
            end
            ST_SCAN:
            begin
                cmd.mul = MUL_SCAN;
                cmd.op  = OP_SCAN;
            end
            ST_SEG_D:  cmd.mul = MUL_DIFF;
            ST_SEG_X:
            begin
                cmd.mul = MUL_RA_DEN;
                cmd.op  = OP_D;
            end
            ST_SEG_N1:
            begin
                cmd.mul = MUL_TA_D;
                cmd.op  = OP_X;
            end
            ST_SEG_N2:
            begin
                cmd.mul = MUL_DT_X;
                cmd.op  = OP_N;
            end
            ST_SEG_N3: cmd.op = OP_NACC;
            ST_DIV0:   cmd.op = OP_DIV_INIT;
            ST_DIV:    cmd.op = OP_DIV_STEP;
            ST_FINISH: cmd.load_out = load_ok;
            default:
            begin
                sample_ready = 1'b0;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ntc_divider_table_temperature.sv -----
// ntc_divider_table_temperature: top level with config registers, controller
// and datapath. Depends on ndt_pkg, ndt_if, ndt_controller, ndt_datapath.
//
// Usage:
//   sample : valid/ready word carrying adc_mv, the divider voltage in mV.
//   result : valid/ready word carrying temp_ddegc (0.1 degC) and range_status
//            (0 valid, 1 voltage above range, 2 voltage below range).
//   cfg    : write word; index 0 supply_mv, 1 fixed_resistor_ohm, 2 ntc_is_upper.
//            Always ready; write only while no sample is in flight.
//   One sample is processed at a time. An above-range result is ready soonest,
//   then a below-range one; an in-range voltage takes longer, more so for a
//   higher seg (0..40), the table segment found. That time is set by the
//   linear table scan (one product per cycle on the shared 42x15 multiplier)
//   and the 12-step restoring divider. The next sample can be taken in the
//   cycle after the result is registered.
//   A finished result waits in the output register; if the receiver stalls
//   while a new result is ready, the sequencer holds until the slot frees.
//   Reset empties the output and restores supply 3000 mV, 10 kohm, lower NTC.
`default_nettype none

module ntc_divider_table_temperature
    import ndt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ndt_in_if.sink      sample,
    ndt_out_if.source   result,
    ndt_cfg_if.sink     cfg
);

    logic [SUPPLY_W-1:0] supply_mv_reg;
    logic [RF_OHM_W-1:0] fixed_resistor_ohm_reg;
    logic                ntc_is_upper_reg;
    ndt_cmd_t            cmd;
    ndt_stat_t           stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_mv_reg          <= SUPPLY_RESET;
            fixed_resistor_ohm_reg <= RF_RESET;
            ntc_is_upper_reg       <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SUPPLY_MV:          supply_mv_reg          <= cfg.data[SUPPLY_W-1:0];
                REG_FIXED_RESISTOR_OHM: fixed_resistor_ohm_reg <= cfg.data[RF_OHM_W-1:0];
                REG_NTC_IS_UPPER:       ntc_is_upper_reg       <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    ndt_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    ndt_datapath u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .stat               (stat),
        .adc_mv             (sample.adc_mv),
        .supply_mv          (supply_mv_reg),
        .fixed_resistor_ohm (fixed_resistor_ohm_reg),
        .ntc_is_upper       (ntc_is_upper_reg),
        .temp_ddegc         (result.temp_ddegc),
        .range_status       (result.range_status)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample accepted while a word is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("pending result word overwritten");

    a_temp_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.range_status == STAT_VALID)) |->
        ((result.temp_ddegc >= TEMP_MIN) && (result.temp_ddegc <= TEMP_MAX)))
        else $error("interpolated temperature outside table span");

    a_range_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.range_status != STAT_VALID)) |->
        (((result.range_status == STAT_ABOVE) && (result.temp_ddegc == TEMP_ABOVE)) ||
         ((result.range_status == STAT_BELOW) && (result.temp_ddegc == TEMP_BELOW))))
        else $error("out-of-range word carries wrong mark");

endmodule

`default_nettype wire

// ----- tb/sv/ntc_divider_table_temperature_tb.sv -----
`timescale 1ns / 1ps
// Testbench for ntc_divider_table_temperature: a queue-fed sample driver, a
// result monitor checked against a local integer model of the divider lookup.
// Depends on ndt_pkg, ndt_if and the block itself.

module ntc_divider_table_temperature_tb
    import ndt_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int PHASES = 12;
    localparam longint ADC_MAX = (1 << ADC_W) - 1;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic [STATUS_W-1:0]      status;
    } reading_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_word_t;

    logic clk = 1'b0;
    logic rst_n;

    ndt_in_if  sample_ch ();
    ndt_out_if result_ch ();
    ndt_cfg_if cfg_ch ();

    ntc_divider_table_temperature dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    logic [ADC_W-1:0]    adc_pending [$];
    cfg_word_t           cfg_pending [$];
    reading_t            readings_due [$];
    reading_t            head_reading;

    logic [SUPPLY_W-1:0] supply_q;
    logic [RF_OHM_W-1:0] rfix_q;
    logic                upper_q;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    function automatic reading_t ntc_temperature(logic [ADC_W-1:0] adc_word);
        longint   adc, vs, rf, r0, rl, num, den, ra, rb, ta, tb, d, n;
        int       i, seg;
        bit       above, below;
        reading_t r;
        adc = adc_word;
        vs  = supply_q;
        rf  = longint'(rfix_q) * OHM_TO_CENTI;
        r0  = TABLE_RES[0];
        rl  = TABLE_RES[TABLE_SIZE-1];
        if (upper_q)
        begin
            above = adc * (rf + rl) > vs * rf;
            below = adc * (rf + r0) < vs * rf;
        end
        else
        begin
            above = adc * (r0 + rf) > vs * r0;
            below = adc * (rl + rf) < vs * rl;
        end
        if (above)
        begin
            r.temp   = TEMP_ABOVE;
            r.status = STAT_ABOVE;
        end
        else if (below)
        begin
            r.temp   = TEMP_BELOW;
            r.status = STAT_BELOW;
        end
        else
        begin
            if (upper_q)
            begin
                num = rf * (vs - adc);
                den = adc;
            end
            else
            begin
                num = rf * adc;
                den = vs - adc;
            end
            // zero or negative divider current: take the coldest entry
            if (den <= 0)
            begin
                num = r0;
                den = 1;
            end
            if (num > r0 * den)
            begin
                num = r0;
                den = 1;
            end
            else if (num < rl * den)
            begin
                num = rl;
                den = 1;
            end
            seg = 0;
            for (i = 0; i < TABLE_SIZE - 1; i++)
            begin
                if (longint'(TABLE_RES[i]) * den > num)
                    seg = i;
            end
            ra = TABLE_RES[seg];
            rb = TABLE_RES[seg+1];
            ta = TABLE_TEMP[seg];
            tb = TABLE_TEMP[seg+1];
            d  = (rb - ra) * den;
            n  = (d == 0) ? ta : (ta * d + (tb - ta) * (num - ra * den)) / d;
            r.temp   = n[TEMP_W-1:0];
            r.status = STAT_VALID;
        end
        return r;
    endfunction

    // divider voltage for a thermistor resistance (centiohm) under the current setup
    function automatic logic [ADC_W-1:0] adc_for_resistance(longint res, int jitter);
        longint vs, rf, v;
        vs = supply_q;
        rf = longint'(rfix_q) * OHM_TO_CENTI;
        if (upper_q)
            v = vs * rf / (rf + res);
        else
            v = vs * res / (res + rf);
        v = v + jitter;
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return v[ADC_W-1:0];
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.adc_mv <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                readings_due.push_back(ntc_temperature(sample_ch.adc_mv));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (adc_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    sample_ch.valid  <= 1'b1;
                    sample_ch.adc_mv <= adc_pending.pop_front();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // config driver and register copy
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data  <= '0;
            supply_q = SUPPLY_RESET;
            rfix_q   = RF_RESET;
            upper_q  = 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_SUPPLY_MV:          supply_q = cfg_ch.data[SUPPLY_W-1:0];
                    REG_FIXED_RESISTOR_OHM: rfix_q   = cfg_ch.data[RF_OHM_W-1:0];
                    REG_NTC_IS_UPPER:       upper_q  = cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (cfg_pending.size() != 0)
                begin
                    cfg_ch.valid <= 1'b1;
                    {cfg_ch.index, cfg_ch.data} <= cfg_pending.pop_front();
                end
                else
                    cfg_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("unexpected result word: temp_ddegc %0d range_status %0d",
                           result_ch.temp_ddegc, result_ch.range_status);
                    mismatches++;
                end
                else
                begin
                    head_reading = readings_due.pop_front();
                    if (result_ch.temp_ddegc !== head_reading.temp)
                    begin
                        $error("temp_ddegc: expected %0d, actual %0d",
                               head_reading.temp, result_ch.temp_ddegc);
                        mismatches++;
                    end
                    if (result_ch.range_status !== head_reading.status)
                    begin
                        $error("range_status: expected %0d, actual %0d",
                               head_reading.status, result_ch.range_status);
                        mismatches++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_word_t w;
        w.index = index;
        w.data  = data;
        cfg_pending.push_back(w);
        while (cfg_pending.size() != 0 || cfg_ch.valid)
            @(negedge clk);
    endtask

    task automatic apply_config(int vs, int rf, bit upper);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        // upper bits of the supply word are don't-care
        write_reg(REG_SUPPLY_MV, {junk[CFG_DATA_W-1:SUPPLY_W], vs[SUPPLY_W-1:0]});
        write_reg(REG_FIXED_RESISTOR_OHM, rf[RF_OHM_W-1:0]);
        write_reg(REG_NTC_IS_UPPER, {junk[CFG_DATA_W-1:1], upper});
    endtask

    task automatic settle();
        while (adc_pending.size() != 0 || sample_ch.valid || readings_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic queue_directed();
        longint r0, rl;
        r0 = TABLE_RES[0];
        rl = TABLE_RES[TABLE_SIZE-1];
        adc_pending.push_back('0);
        adc_pending.push_back(ADC_MAX[ADC_W-1:0]);
        adc_pending.push_back(14'h2AAA);
        adc_pending.push_back(14'h1555);
        adc_pending.push_back(adc_for_resistance(r0, 0));
        adc_pending.push_back(adc_for_resistance(r0, 1));
        adc_pending.push_back(adc_for_resistance(rl, 0));
        adc_pending.push_back(adc_for_resistance(rl, 1));
        // 25 degC entry equals the fixed resistor: lands exactly on a table point
        adc_pending.push_back(adc_for_resistance(TABLE_RES[16], 0));
        adc_pending.push_back(adc_for_resistance(TABLE_RES[1], 0));
        adc_pending.push_back(adc_for_resistance(TABLE_RES[TABLE_SIZE-2], 0));
    endtask

    task automatic queue_random_items(int count);
        int     k, pick, seg;
        longint lo, res;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                seg = $urandom_range(TABLE_SIZE - 2);
                lo  = TABLE_RES[seg+1];
                res = lo + $urandom_range(TABLE_RES[seg] - TABLE_RES[seg+1]);
                adc_pending.push_back(adc_for_resistance(res, int'($urandom_range(2)) - 1));
            end
            else if (pick < 80)
            begin
                res = $urandom_range(1) ? TABLE_RES[0] : TABLE_RES[TABLE_SIZE-1];
                adc_pending.push_back(adc_for_resistance(res, int'($urandom_range(6)) - 3));
            end
            else
                adc_pending.push_back(ADC_W'($urandom()));
        end
    endtask

    initial
    begin
        int p, vs, rf;
        bit upper;
        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.adc_mv = '0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset setup, then thermistor on top
        queue_directed();
        settle();
        write_reg(REG_NTC_IS_UPPER, 20'd1);
        queue_directed();
        settle();

        // zero supply
        apply_config(0, 10000, 0);
        adc_pending.push_back(14'd0);
        adc_pending.push_back(14'd1);
        adc_pending.push_back(ADC_MAX[ADC_W-1:0]);
        settle();

        // zero fixed resistor, both positions
        apply_config(3000, 0, 0);
        adc_pending.push_back(14'd3000);
        adc_pending.push_back(14'd2999);
        adc_pending.push_back(14'd3001);
        settle();
        write_reg(REG_NTC_IS_UPPER, 20'd1);
        adc_pending.push_back(14'd0);
        adc_pending.push_back(14'd1);
        settle();

        // write to an index past the register list is dropped
        apply_config(3000, 10000, 0);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        adc_pending.push_back(14'd1500);
        settle();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin vs = 16383; rf = 1000000; upper = 1'b1; end
                1:       begin vs = 16383; rf = 1000000; upper = 1'b0; end
                2:       begin vs = 1;     rf = 1;       upper = 1'b0; end
                3:       begin vs = 1;     rf = 1;       upper = 1'b1; end
                4:       begin vs = 3300;  rf = 4700;    upper = 1'b0; end
                5:       begin vs = 5000;  rf = 100000;  upper = 1'b1; end
                11:
                begin
                    vs    = $urandom_range(16383, 500);
                    rf    = $urandom_range(20'hFFFFF);
                    upper = 1'($urandom_range(1));
                end
                default:
                begin
                    vs    = $urandom_range(16383, 500);
                    rf    = $urandom_range(200000, 1000);
                    upper = 1'($urandom_range(1));
                end
            endcase
            apply_config(vs, rf, upper);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            queue_random_items(ITEMS_PER_PHASE);
            settle();
        end

        repeat (100) @(negedge clk);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ndt_pkg.sv
rtl/ndt_if.sv
rtl/ndt_datapath.sv
rtl/ndt_controller.sv
rtl/ntc_divider_table_temperature.sv
tb/sv/ntc_divider_table_temperature_tb.sv
